// ----- rtl/core/keyed_lfsr_matrix_keystream_core_defines.svh -----
// Assertion helpers for the keystream core. Both expect clk_i and rst_ni in scope.
`ifndef KEYED_LFSR_MATRIX_KEYSTREAM_CORE_DEFINES_SVH
`define KEYED_LFSR_MATRIX_KEYSTREAM_CORE_DEFINES_SVH

// Same-cycle implication.
`define KLMK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KLMK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/klmk_pkg.sv -----
package klmk_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned START_W    = 16;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned NUM_LANES  = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned MAT_DEPTH  = 64;
  localparam int unsigned MAT_AW     = 6;

  localparam int unsigned WARMUP_STEPS_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WIDE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BATCH = 2'd3;

  localparam logic [WORD_W-1:0] MUL_A = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MUL_B = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MUL_C = 64'h94D049BB133111EB;
  localparam logic [7:0]        GF_POLY = 8'h1B;

  localparam logic [WORD_W-1:0] TAPS [NUM_LANES] = '{
    64'h4800203343401101, 64'h0416001300480117,
    64'h58000C0310100803, 64'h00A0090940648023,
    64'h484302010C340003, 64'h801D001006412901,
    64'h04429288080A1021, 64'h2000022052D01213
  };

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] p;
  } mul_rsp_t;

  function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] x, logic [5:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] x, logic [2:0] n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  // Byte-wise multiply by two in GF(2^8).
  function automatic logic [WORD_W-1:0] xtime64(logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k*8 +: 8] = {x[k*8 +: 7], 1'b0} ^ (x[k*8+7] ? GF_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/klmk_in_if.sv -----
interface klmk_in_if import klmk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [START_W-1:0] start_index;

  modport source (output valid, mode, start_index, input ready);
  modport sink   (input valid, mode, start_index, output ready);
endinterface

// ----- rtl/core/klmk_out_if.sv -----
interface klmk_out_if import klmk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;
  logic              key_accepted;

  modport source (output valid, word, last, key_accepted, input ready);
  modport sink   (input valid, word, last, key_accepted, output ready);
endinterface

// ----- rtl/core/klmk_mul.sv -----
// Low 64 bits of a 64x64 product from one 32x32 multiplier over three passes.
module klmk_mul import klmk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned HALF_W = WORD_W / 2;

  logic              run_q, run_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] a_q, b_q;
  logic [WORD_W-1:0] pr_q, lo_q, p_q;
  logic [HALF_W-1:0] x_q;
  logic [HALF_W-1:0] op_a, op_b;

  always_comb begin
    case (cnt_q)
      2'd0:    begin op_a = a_q[HALF_W-1:0];      op_b = b_q[HALF_W-1:0];      end
      2'd1:    begin op_a = a_q[HALF_W-1:0];      op_b = b_q[WORD_W-1:HALF_W]; end
      2'd2:    begin op_a = a_q[WORD_W-1:HALF_W]; op_b = b_q[HALF_W-1:0];      end
      default: begin op_a = '0;                   op_b = '0;                   end
    endcase
  end

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start && !run_q) begin
      run_d = 1'b1;
      cnt_d = 2'd0;
    end else if (run_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !run_q) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (run_q) begin
      pr_q <= op_a * op_b;
      if (cnt_q == 2'd1) lo_q <= pr_q;
      if (cnt_q == 2'd2) x_q  <= pr_q[HALF_W-1:0];
      if (cnt_q == 2'd3) p_q  <= lo_q + {x_q + pr_q[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

// ----- rtl/core/keyed_lfsr_matrix_keystream_core.sv -----
// Keystream core: eight Galois LFSRs and a 64-byte matrix held in a one-port-read memory.
// Every 64-bit product goes through one shared multiplier. Items (one-word, wide or batch)
// are taken one at a time; a new one is accepted only in idle. Init: key products, mixing,
// matrix fill, then the warm-up steps (a zero key skips all of these). Reset is asynchronous,
// active low; matrix entries read as zero until written, through per-entry valid bits.
`include "keyed_lfsr_matrix_keystream_core_defines.svh"

module keyed_lfsr_matrix_keystream_core import klmk_pkg::*; #(
  parameter int unsigned WARMUP_STEPS = WARMUP_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  klmk_in_if.sink              in_ch_i,
  klmk_out_if.source           out_ch_o
);

  localparam int unsigned WCNT_W = $clog2(WARMUP_STEPS + 1);

  typedef enum logic [21:0] {
    S_IDLE  = 22'd1 << 0,
    S_KMUL1 = 22'd1 << 1,
    S_KMUL2 = 22'd1 << 2,
    S_MIX   = 22'd1 << 3,
    S_FILL  = 22'd1 << 4,
    S_RD    = 22'd1 << 5,
    S_CLK   = 22'd1 << 6,
    S_M1    = 22'd1 << 7,
    S_M2    = 22'd1 << 8,
    S_M3    = 22'd1 << 9,
    S_W1    = 22'd1 << 10,
    S_W2    = 22'd1 << 11,
    S_W3    = 22'd1 << 12,
    S_W4    = 22'd1 << 13,
    S_BRD   = 22'd1 << 14,
    S_BRW   = 22'd1 << 15,
    S_BCLK  = 22'd1 << 16,
    S_FB    = 22'd1 << 17,
    S_FBR   = 22'd1 << 18,
    S_FBA   = 22'd1 << 19,
    S_FBB   = 22'd1 << 20,
    S_EMIT  = 22'd1 << 21
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // Control state.
  logic [WORD_W-1:0] key_q [NUM_LANES];
  logic [WORD_W-1:0] lfsr_q [NUM_LANES];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [WCNT_W-1:0] warm_q, warm_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              sent_q, sent_d;
  logic              out_valid_q, out_valid_d;
  logic [MAT_DEPTH-1:0] mvalid_q;
  logic              rvalid_q;

  // Datapath registers.
  logic [WORD_W-1:0] kr_q [NUM_LANES];
  logic [WORD_W-1:0] mm_q [NUM_LANES];
  logic [WORD_W-1:0] t_q, raw_q, tt_q, vx_q;
  logic [7:0]        cur_q, ba_q;
  logic              c_q;
  logic [6:0]        extra_q;
  logic [15:0]       fb_q;
  logic [7:0]        mask_q [NUM_LANES];
  logic [15:0]       fbbuf_q [NUM_LANES];
  logic [WORD_W-1:0] pw_q, pw_d;
  logic              pl_q, pl_d, pk_q, pk_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q, out_ka_q;

  // Matrix memory.
  logic [7:0]        mix_mem [MAT_DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_re, mem_we;
  logic [MAT_AW-1:0] raddr, waddr;
  logic [7:0]        wdata, rd_val;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [2:0]        ci;
  logic [POS_W-1:0]  tpos;
  logic [2:0]        laddr;
  logic [5:0]        ramt;
  logic              key_any;
  logic              in_acc, out_acc, emit_load;
  logic              mul_state;
  logic [WORD_W-1:0] lfsr_nx [NUM_LANES];
  logic [WORD_W-1:0] vx_nx, vx_acc;
  logic [WORD_W-1:0] mix_x;
  logic [WORD_W-1:0] mm_sel, key_sel;
  logic [7:0]        ek;
  logic [15:0]       fbp;

  klmk_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign ci     = cnt_q[2:0];
  assign tpos   = pos_q + {6'd0, ci};
  assign laddr  = pos_q[2:0] + {ci[1:0], 1'b0};
  assign ramt   = {ci[1:0], 4'd0} + {4'd0, ci[1:0]};
  assign rd_val = rvalid_q ? rdata_q : 8'h00;

  always_comb begin
    key_any = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) key_any = key_any | (|key_q[i]);
  end

  // All LFSRs advance together; their XOR is whitened by a 33-bit rotation.
  always_comb begin
    vx_acc = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      lfsr_nx[i] = {lfsr_q[i][WORD_W-2:0], 1'b0} ^ (TAPS[i] & {WORD_W{lfsr_q[i][WORD_W-1]}});
      vx_acc     = vx_acc ^ lfsr_nx[i];
    end
    vx_nx = vx_acc ^ rotl64(vx_acc, 6'd33);
  end

  // The circulant mix is shift invariant, so it works on whole words byte-parallel.
  always_comb begin
    mix_x = '0;
    for (int i = 0; i < NUM_LANES; i++) mix_x = mix_x ^ mm_q[i];
  end

  assign mm_sel  = mm_q[cnt_q[5:3]];
  assign key_sel = key_q[cnt_q[5:3]];
  assign ek      = {1'b0, extra_q} * key_sel[{cnt_q[2:0], 3'b000} +: 8];
  assign fbp     = (mode_q == MODE_BATCH ? fbbuf_q[ci] : raw_q[15:0]) * MUL_A[15:0];

  always_comb begin
    mul_state = 1'b0;
    mul_req.a = '0;
    mul_req.b = '0;
    case (state_q)
      S_KMUL1: begin mul_state = 1'b1; mul_req.a = kr_q[0]; mul_req.b = rotl64(kr_q[1], 6'd23); end
      S_KMUL2: begin mul_state = 1'b1; mul_req.a = t_q; mul_req.b = rotl64(kr_q[2], 6'd41); end
      S_M1:    begin mul_state = 1'b1; mul_req.a = {56'd0, cur_q}; mul_req.b = MUL_A; end
      S_M2:    begin mul_state = 1'b1; mul_req.a = vx_q; mul_req.b = t_q; end
      S_M3:    begin mul_state = 1'b1; mul_req.a = t_q; mul_req.b = MUL_B; end
      S_W1:    begin mul_state = 1'b1; mul_req.a = lfsr_q[laddr]; mul_req.b = {56'd0, cur_q}; end
      S_W2: begin
        mul_state = 1'b1;
        mul_req.a = t_q;
        mul_req.b = {57'd0, cur_q[6:1], 1'b1};
      end
      S_W3:    begin mul_state = 1'b1; mul_req.a = t_q; mul_req.b = MUL_C; end
      S_W4:    begin mul_state = 1'b1; mul_req.a = raw_q; mul_req.b = rotl64(tt_q, ramt); end
      default: begin mul_state = 1'b0; end
    endcase
    mul_req.start = mul_state && !sent_q;
  end

  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = {pos_q[2:0], pos_q[5:3]};
    waddr  = {pos_q[2:0], pos_q[5:3]};
    wdata  = 8'h00;
    case (state_q)
      S_RD:  mem_re = 1'b1;
      S_BRD: begin mem_re = 1'b1; raddr = {tpos[2:0], tpos[5:3]}; end
      S_FB:  mem_re = 1'b1;
      S_FBR: begin mem_re = 1'b1; raddr = {pos_q[2:1], ~pos_q[0], pos_q[5:3]}; end
      S_FBA: begin mem_we = 1'b1; wdata = rotl8(ba_q ^ fb_q[7:0], pos_q[8:6]); end
      S_FBB: begin
        mem_we = 1'b1;
        waddr  = {pos_q[2:1], ~pos_q[0], pos_q[5:3]};
        wdata  = rd_val ^ fb_q[15:8];
      end
      S_FILL: begin
        mem_we = 1'b1;
        waddr  = cnt_q;
        wdata  = mm_sel[{cnt_q[2:0], 3'b000} +: 8] ^ {1'b0, ek[6:0]};
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mix_mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mix_mem[raddr];
  end

  assign in_acc    = in_ch_i.valid && in_ch_i.ready;
  assign out_acc   = out_ch_o.valid && out_ch_o.ready;
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ch_o.ready);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    warm_d      = warm_q;
    mode_d      = mode_q;
    sent_d      = sent_q;
    pw_d        = pw_q;
    pl_d        = pl_q;
    pk_d        = pk_q;
    out_valid_d = out_valid_q;

    if (out_acc) out_valid_d = 1'b0;
    if (emit_load) out_valid_d = 1'b1;

    if (mul_req.start) sent_d = 1'b1;
    if (mul_state && sent_q && mul_rsp.done) sent_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d = in_ch_i.mode;
          cnt_d  = '0;
          case (in_ch_i.mode)
            MODE_INIT: begin
              if (key_any) begin
                pos_d   = in_ch_i.start_index[POS_W-1:0];
                warm_d  = '0;
                state_d = S_KMUL1;
              end else begin
                pw_d    = '0;
                pl_d    = 1'b1;
                pk_d    = 1'b0;
                ret_d   = S_IDLE;
                state_d = S_EMIT;
              end
            end
            MODE_BATCH: state_d = S_BRD;
            default:    state_d = S_RD;
          endcase
        end
      end
      S_KMUL1: if (sent_q && mul_rsp.done) state_d = S_KMUL2;
      S_KMUL2: begin
        if (sent_q && mul_rsp.done) begin
          if (ci == 3'd7) begin
            cnt_d   = '0;
            state_d = S_MIX;
          end else begin
            cnt_d   = cnt_q + 6'd1;
            state_d = S_KMUL1;
          end
        end
      end
      S_MIX: state_d = S_FILL;
      S_FILL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(MAT_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD:  state_d = S_CLK;
      S_CLK: state_d = S_M1;
      S_M1:  if (sent_q && mul_rsp.done) state_d = S_M2;
      S_M2:  if (sent_q && mul_rsp.done) state_d = S_M3;
      S_M3: begin
        if (sent_q && mul_rsp.done) begin
          case (mode_q)
            MODE_INIT: state_d = S_FB;
            MODE_ONE: begin
              pw_d    = mul_rsp.p ^ {WORD_W{c_q}};
              pl_d    = 1'b1;
              pk_d    = 1'b0;
              ret_d   = S_FB;
              state_d = S_EMIT;
            end
            MODE_WIDE: begin
              cnt_d   = '0;
              state_d = S_W1;
            end
            default: begin
              pw_d    = mul_rsp.p ^ {WORD_W{mask_q[ci][tpos[8:6]]}};
              pl_d    = (ci == 3'd7);
              pk_d    = 1'b0;
              ret_d   = (ci == 3'd7) ? S_FB : S_BCLK;
              cnt_d   = (ci == 3'd7) ? 6'd0 : cnt_q + 6'd1;
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_W1: if (sent_q && mul_rsp.done) state_d = S_W2;
      S_W2: if (sent_q && mul_rsp.done) state_d = S_W3;
      S_W3: if (sent_q && mul_rsp.done) state_d = S_W4;
      S_W4: begin
        if (sent_q && mul_rsp.done) begin
          pw_d    = mul_rsp.p ^ {WORD_W{c_q}} ^ lfsr_q[laddr];
          pl_d    = (ci == 3'd3);
          pk_d    = 1'b0;
          ret_d   = (ci == 3'd3) ? S_FB : S_W4;
          cnt_d   = (ci == 3'd3) ? 6'd0 : cnt_q + 6'd1;
          state_d = S_EMIT;
        end
      end
      S_BRD: state_d = S_BRW;
      S_BRW: begin
        if (ci == 3'd7) begin
          cnt_d   = '0;
          state_d = S_BCLK;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = S_BRD;
        end
      end
      S_BCLK: state_d = S_M1;
      S_FB:   state_d = S_FBR;
      S_FBR:  state_d = S_FBA;
      S_FBA:  state_d = S_FBB;
      S_FBB: begin
        pos_d = pos_q + 9'd1;
        case (mode_q)
          MODE_INIT: begin
            if (warm_q == WCNT_W'(WARMUP_STEPS - 1)) begin
              pw_d    = '0;
              pl_d    = 1'b1;
              pk_d    = 1'b1;
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end else begin
              warm_d  = warm_q + WCNT_W'(1);
              state_d = S_RD;
            end
          end
          MODE_BATCH: begin
            if (ci == 3'd7) begin
              state_d = S_IDLE;
            end else begin
              cnt_d   = cnt_q + 6'd1;
              state_d = S_FB;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT: if (emit_load) state_d = ret_q;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      warm_q      <= '0;
      mode_q      <= MODE_INIT;
      sent_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mvalid_q    <= '0;
      rvalid_q    <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        key_q[i]  <= '0;
        lfsr_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      warm_q      <= warm_d;
      mode_q      <= mode_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
      if (mem_we) mvalid_q[waddr] <= 1'b1;
      if (mem_re) rvalid_q <= mvalid_q[raddr];
      if (cfg_we_i && !cfg_idx_i[CFG_IDX_W-1]) begin
        key_q[cfg_idx_i[CFG_IDX_W-2:0]] <= cfg_wdata_i;
      end
      if (state_q == S_CLK || state_q == S_BCLK) begin
        for (int i = 0; i < NUM_LANES; i++) lfsr_q[i] <= lfsr_nx[i];
      end
      if (state_q == S_FILL && cnt_q == 6'(MAT_DEPTH - 1)) begin
        // The LFSR bank takes the mixed words rotated by four lanes.
        for (int i = 0; i < NUM_LANES; i++) lfsr_q[i] <= mm_q[(i + 4) % NUM_LANES];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      extra_q <= in_ch_i.start_index[START_W-1:POS_W];
      for (int i = 0; i < NUM_LANES; i++) kr_q[i] <= key_q[i];
    end
    if (state_q == S_KMUL1 && sent_q && mul_rsp.done) t_q <= mul_rsp.p;
    if (state_q == S_KMUL2 && sent_q && mul_rsp.done) begin
      for (int i = 0; i < NUM_LANES - 1; i++) begin
        mm_q[i] <= mm_q[i+1];
        kr_q[i] <= kr_q[i+1];
      end
      mm_q[NUM_LANES-1] <= mul_rsp.p;
      kr_q[NUM_LANES-1] <= kr_q[0];
    end
    if (state_q == S_MIX) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        mm_q[i] <= mix_x ^ mm_q[i] ^ xtime64(mm_q[i]) ^ xtime64(mm_q[(i + 1) % NUM_LANES]);
      end
    end
    if (state_q == S_CLK) begin
      cur_q <= rd_val;
      c_q   <= rd_val[pos_q[8:6]];
      vx_q  <= vx_nx;
    end
    if (state_q == S_BCLK) begin
      cur_q <= mask_q[ci];
      vx_q  <= vx_nx;
    end
    if (state_q == S_BRW) mask_q[ci] <= rd_val;
    if (state_q == S_M1 && sent_q && mul_rsp.done) t_q <= mul_rsp.p | 64'd1;
    if (state_q == S_M2 && sent_q && mul_rsp.done) t_q <= mul_rsp.p;
    if (state_q == S_M3 && sent_q && mul_rsp.done) begin
      raw_q          <= mul_rsp.p;
      fbbuf_q[ci]    <= mul_rsp.p[15:0];
    end
    if ((state_q == S_W1 || state_q == S_W2) && sent_q && mul_rsp.done) t_q <= mul_rsp.p;
    if (state_q == S_W3 && sent_q && mul_rsp.done) tt_q <= rotl64(mul_rsp.p, 6'd33);
    if (state_q == S_FB) fb_q <= fbp;
    if (state_q == S_FBR) ba_q <= rd_val;
    pw_q <= pw_d;
    pl_q <= pl_d;
    pk_q <= pk_d;
    if (emit_load) begin
      out_word_q <= pw_q;
      out_last_q <= pl_q;
      out_ka_q   <= pk_q;
    end
  end

  assign in_ch_i.ready         = (state_q == S_IDLE);
  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.word         = out_word_q;
  assign out_ch_o.last         = out_last_q;
  assign out_ch_o.key_accepted = out_ka_q;

  `KLMK_ASSERT_NOW(a_mul_free, mul_req.start, !mul_rsp.busy, "multiplier started while busy")
  `KLMK_ASSERT_NEXT(a_in_leaves_idle, in_acc, state_q != S_IDLE, "accepted word left core idle")
  `KLMK_ASSERT_NOW(a_mem_no_overlap, mem_we && mem_re, waddr != raddr, "matrix read/write overlap")
  `KLMK_ASSERT_NEXT(a_emit_holds, (state_q == S_EMIT) && out_valid_q && !out_ch_o.ready,
                    state_q == S_EMIT, "pending word dropped while output stalled")

endmodule
